FILE: rtl/bmims_pkg.sv
// ----------------------------------------------------------------------------
// bmims_pkg: shared types and constants for the BMI median/mean statistics core
// Record and result payloads, cell link and divider structs, sequencer states.
// ----------------------------------------------------------------------------
package bmims_pkg;

	localparam int MAX_ITEMS = 16;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	localparam int H_W     = 12;
	localparam int W_W     = 13;
	localparam int BMI_W   = 16;
	localparam int SUM_W   = BMI_W + IDX_W;
	localparam int SCALE_W = 25;
	localparam int NUM_W   = W_W + SCALE_W;
	localparam int DEN_W   = 2 * H_W;
	localparam int STEP_W  = $clog2(BMI_W);

	// 256 * 10 * 1000^2 / 100: Q8.8 scale with tenths-of-kg and tenths-of-cm units
	localparam logic [SCALE_W-1:0] BMI_SCALE = 25'd25600000;
	localparam logic [BMI_W-1:0]   BMI_MAX   = '1;

	typedef struct packed {
		logic [H_W-1:0] height_tenth_cm;
		logic [W_W-1:0] weight_tenth_kg;
		logic           is_last;
	} rec_t;

	typedef struct packed {
		logic [BMI_W-1:0] bmi_q8_8;
		logic [BMI_W-1:0] median_q8_8;
		logic [BMI_W-1:0] mean_q8_8;
		logic             stats_valid;
		logic             dropped;
	} res_t;

	typedef struct packed {
		logic             take;
		logic             occ;
		logic [BMI_W-1:0] val;
	} cell_link_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [BMI_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_BGO,
		ST_BDIV,
		ST_INS,
		ST_MLO,
		ST_MHI,
		ST_MDIV,
		ST_OUT
	} state_t;

endpackage

FILE: rtl/bmims_ifs.sv
// ----------------------------------------------------------------------------
// bmims_ifs: record and result channels
// Valid/ready channels; a transaction moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface bmims_rec_if;
	logic            valid;
	logic            ready;
	bmims_pkg::rec_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface bmims_res_if;
	logic            valid;
	logic            ready;
	bmims_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/bmims_cell.sv
// ----------------------------------------------------------------------------
// bmims_cell: one slot of the sorted insertion chain
// Holds one value; on insert, keeps it, shifts in its neighbor's, or takes new.
// ----------------------------------------------------------------------------
module bmims_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              ins,
	input  logic                              clr,
	input  logic [bmims_pkg::BMI_W-1:0]       v,
	input  bmims_pkg::cell_link_t             prev,
	output bmims_pkg::cell_link_t             link
);

	logic                        occ_q;
	logic [bmims_pkg::BMI_W-1:0] val_q;
	logic                        take;

	// empty slot or larger value: this slot moves
	assign take = !occ_q || (val_q > v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (clr) begin
			occ_q <= 1'b0;
		end else if (ins) begin
			occ_q <= occ_q | prev.occ;
		end
	end

	always_ff @(posedge clk) begin
		if (ins && take) begin
			val_q <= prev.take ? prev.val : v;
		end
	end

	assign link = '{take: take, occ: occ_q, val: val_q};

endmodule

FILE: rtl/bmims_div.sv
// ----------------------------------------------------------------------------
// bmims_div: restoring divider, one quotient bit per cycle
// 16-bit quotient; zero divisor or quotient overflow saturates to all ones.
// ----------------------------------------------------------------------------
module bmims_div (
	input  logic                clk,
	input  logic                arst_n,
	input  bmims_pkg::div_req_t req,
	output bmims_pkg::div_rsp_t rsp
);

	localparam int REM_W = bmims_pkg::DEN_W + bmims_pkg::BMI_W;

	logic                         busy_q;
	logic                         done_q;
	logic [REM_W-1:0]             rem_q;
	logic [REM_W-1:0]             dsh_q;
	logic [bmims_pkg::BMI_W-1:0]  quo_q;
	logic [bmims_pkg::STEP_W-1:0] step_q;
	logic                         sat;
	logic                         ge;

	assign sat = (req.divisor == '0) ||
		(REM_W'(req.dividend) >= {req.divisor, {bmims_pkg::BMI_W{1'b0}}});
	assign ge = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= !sat;
				done_q <= sat;
			end else if (busy_q && (step_q == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= REM_W'(req.dividend);
			dsh_q  <= REM_W'({req.divisor, {(bmims_pkg::BMI_W - 1){1'b0}}});
			step_q <= bmims_pkg::STEP_W'(bmims_pkg::BMI_W - 1);
			quo_q  <= bmims_pkg::BMI_MAX;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q  <= {quo_q[bmims_pkg::BMI_W-2:0], ge};
			dsh_q  <= dsh_q >> 1;
			step_q <= step_q - 1'b1;
		end
	end

	assign rsp = '{done: done_q, quotient: quo_q};

endmodule

FILE: rtl/bmi_median_mean_stats_core.sv
// ----------------------------------------------------------------------------
// bmi_median_mean_stats_core: running BMI with median and mean of a record set
// Per record BMI in Q8.8, sorted insertion chain, running sum, set statistics.
// ----------------------------------------------------------------------------
// Each record transaction (height in 0.1 cm, weight in 0.1 kg, last flag) gives
// one result transaction. BMI = floor(weight * 25600000 / height^2) in Q8.8,
// saturated to 65535 for zero height or overflow. While fewer than 16 values
// are stored, the BMI is inserted into an ascending chain of 16 cells and added
// to a running sum; otherwise the result carries dropped = 1 and nothing is
// stored. On the record marked last the result also carries the median (mean
// of the two middle values for an even count) and the truncated mean of the
// stored set with stats_valid = 1, and the set is cleared for the next one.
// One record is in flight at a time; its BMI passes through the 16 steps of the
// shared serial divider. A last record also runs the mean division through the
// same divider, and a saturated BMI skips the divider steps. A finished result
// waits in an output register, so the next record can be accepted while it is
// still pending.
// ----------------------------------------------------------------------------
module bmi_median_mean_stats_core (
	input  logic               clk,
	input  logic               arst_n,
	bmims_rec_if.sink          records,
	bmims_res_if.source        results
);

	localparam int N = bmims_pkg::MAX_ITEMS;

	// sequencer
	bmims_pkg::state_t state_q, state_d;

	// sequencer outputs
	logic rec_take;
	logic div_go;
	logic ins_en;
	logic rd_lo;
	logic rd_hi;
	logic out_load;
	logic clr_en;

	// datapath registers
	bmims_pkg::rec_t                rec_q;
	logic [bmims_pkg::NUM_W-1:0]    num_q;
	logic [bmims_pkg::DEN_W-1:0]    den_q;
	logic [bmims_pkg::BMI_W-1:0]    bmi_q;
	logic                           drop_q;
	logic [bmims_pkg::BMI_W-1:0]    lo_q;
	logic [bmims_pkg::BMI_W-1:0]    hi_q;
	logic [bmims_pkg::CNT_W-1:0]    count_q;
	logic [bmims_pkg::SUM_W-1:0]    sum_q;

	// output register
	logic                           out_valid_q;
	bmims_pkg::res_t                out_q;
	logic                           out_free;

	// divider
	bmims_pkg::div_req_t            div_req;
	bmims_pkg::div_rsp_t            div_rsp;

	// cell chain
	bmims_pkg::cell_link_t          link [N];
	bmims_pkg::cell_link_t          head;
	logic [bmims_pkg::BMI_W-1:0]    cell_val [N];
	logic [bmims_pkg::CNT_W-1:0]    mid;
	logic [bmims_pkg::IDX_W-1:0]    rd_idx;
	logic [bmims_pkg::BMI_W-1:0]    rd_val;

	// result assembly
	logic                           room;
	logic                           stats_ok;
	logic [bmims_pkg::BMI_W:0]      mid_sum;
	logic [bmims_pkg::BMI_W-1:0]    median;
	bmims_pkg::res_t                res;

	assign out_free = !out_valid_q || results.ready;
	assign room     = (count_q < bmims_pkg::CNT_W'(N));

	// ------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			bmims_pkg::ST_IDLE: begin
				if (records.valid) begin
					state_d = bmims_pkg::ST_MUL;
				end
			end
			bmims_pkg::ST_MUL:  state_d = bmims_pkg::ST_BGO;
			bmims_pkg::ST_BGO:  state_d = bmims_pkg::ST_BDIV;
			bmims_pkg::ST_BDIV: begin
				if (div_rsp.done) begin
					state_d = bmims_pkg::ST_INS;
				end
			end
			bmims_pkg::ST_INS: begin
				state_d = rec_q.is_last ? bmims_pkg::ST_MLO : bmims_pkg::ST_OUT;
			end
			bmims_pkg::ST_MLO: begin
				// empty set: no statistics to gather
				state_d = (count_q == '0) ? bmims_pkg::ST_OUT : bmims_pkg::ST_MHI;
			end
			bmims_pkg::ST_MHI:  state_d = bmims_pkg::ST_MDIV;
			bmims_pkg::ST_MDIV: begin
				if (div_rsp.done) begin
					state_d = bmims_pkg::ST_OUT;
				end
			end
			bmims_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = bmims_pkg::ST_IDLE;
				end
			end
			default: state_d = bmims_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: outputs
	// ------------------------------------------------------------------
	always_comb begin
		rec_take = 1'b0;
		div_go   = 1'b0;
		ins_en   = 1'b0;
		rd_lo    = 1'b0;
		rd_hi    = 1'b0;
		out_load = 1'b0;
		clr_en   = 1'b0;
		case (state_q)
			bmims_pkg::ST_IDLE: rec_take = 1'b1;
			bmims_pkg::ST_BGO:  div_go   = 1'b1;
			bmims_pkg::ST_INS:  ins_en   = room;
			bmims_pkg::ST_MLO: begin
				rd_lo  = 1'b1;
				div_go = (count_q != '0);
			end
			bmims_pkg::ST_MHI:  rd_hi = 1'b1;
			bmims_pkg::ST_OUT: begin
				out_load = out_free;
				clr_en   = out_free && rec_q.is_last;
			end
			default: ;
		endcase
	end

	assign records.ready = rec_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmims_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Record capture and BMI operands: numerator and denominator products
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (rec_take && records.valid) begin
			rec_q <= records.data;
		end
		if (state_q == bmims_pkg::ST_MUL) begin
			num_q <= bmims_pkg::NUM_W'(rec_q.weight_tenth_kg) *
				bmims_pkg::NUM_W'(bmims_pkg::BMI_SCALE);
			den_q <= bmims_pkg::DEN_W'(rec_q.height_tenth_cm) *
				bmims_pkg::DEN_W'(rec_q.height_tenth_cm);
		end
		if ((state_q == bmims_pkg::ST_BDIV) && div_rsp.done) begin
			bmi_q <= div_rsp.quotient;
		end
		if (state_q == bmims_pkg::ST_INS) begin
			drop_q <= !room;
		end
		if (rd_lo) begin
			lo_q <= rd_val;
		end
		if (rd_hi) begin
			hi_q <= rd_val;
		end
	end

	// ------------------------------------------------------------------
	// Shared divider: BMI first, then the mean on a last record
	// ------------------------------------------------------------------
	always_comb begin
		div_req.start = div_go;
		if (state_q == bmims_pkg::ST_MLO) begin
			div_req.dividend = bmims_pkg::NUM_W'(sum_q);
			div_req.divisor  = bmims_pkg::DEN_W'(count_q);
		end else begin
			div_req.dividend = num_q;
			div_req.divisor  = den_q;
		end
	end

	bmims_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ------------------------------------------------------------------
	// Set bookkeeping: count and running sum; clear after a last record
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (clr_en) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (ins_en) begin
			count_q <= count_q + 1'b1;
			sum_q   <= sum_q + bmims_pkg::SUM_W'(bmi_q);
		end
	end

	// ------------------------------------------------------------------
	// Sorted insertion chain: cell 0 holds the smallest value
	// ------------------------------------------------------------------
	assign head = '{take: 1'b0, occ: 1'b1, val: '0};

	for (genvar i = 0; i < N; i++) begin : g_cell
		bmims_pkg::cell_link_t prev;

		if (i == 0) begin : g_first
			assign prev = head;
		end else begin : g_next
			assign prev = link[i-1];
		end

		bmims_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ins    (ins_en),
			.clr    (clr_en),
			.v      (bmi_q),
			.prev   (prev),
			.link   (link[i])
		);

		assign cell_val[i] = link[i].val;
	end

	// one chain read per cycle: the lower middle value, then the upper one
	assign mid    = count_q >> 1;
	assign rd_idx = rd_lo ? bmims_pkg::IDX_W'(mid - 1'b1) : bmims_pkg::IDX_W'(mid);
	assign rd_val = cell_val[rd_idx];

	// ------------------------------------------------------------------
	// Result assembly and output register
	// ------------------------------------------------------------------
	assign stats_ok = rec_q.is_last && (count_q != '0);
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign median   = count_q[0] ? hi_q : mid_sum[bmims_pkg::BMI_W:1];

	always_comb begin
		res.bmi_q8_8    = bmi_q;
		res.median_q8_8 = stats_ok ? median : '0;
		res.mean_q8_8   = stats_ok ? div_rsp.quotient : '0;
		res.stats_valid = stats_ok;
		res.dropped     = drop_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result until the transaction completes
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_q;

endmodule
